[rtl/hcb_pkg.sv]
// hcb_pkg: shared types for the huffman code builder
// holds the sequencer state enum; no dependencies
package hcb_pkg;

  typedef enum logic [2:0] {
    S_LOAD,
    S_BUILD,
    S_WRD,
    S_WEV,
    S_POP
  } hcb_state_t;

endpackage

[rtl/huffman_code_builder.sv]
// huffman_code_builder: loads symbol/weight words, builds the code tree, walks it out
// uses hcb_pkg for the sequencer state type
// node table and walk stack are synchronous memories with registered read data
//
// Usage: load symbols one per cycle (start high while busy is low). A word with
// in_last_symbol set starts the build; busy stays high until the last code is out.
// With K symbols held, the build does K-1 merges of the two lowest queue entries,
// one per cycle, the parent re-inserted by the sorted queue row in the same cycle;
// then the root is handed to the walk.
// The depth-first walk then reads the node table and evaluates each tree node in turn,
// with a walk stack read for each stack pop.
// One code word is strobed on out_valid per leaf, in walk order; the receiver cannot
// stall and must take each word in the cycle it is shown.
module huffman_code_builder #(
  parameter int MAX_SYMBOLS = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_symbol,
  input  logic [15:0] in_weight,
  input  logic        in_last_symbol,
  output logic        out_valid,
  output logic [7:0]  out_code_symbol,
  output logic [14:0] out_code_bits,
  output logic [3:0]  out_code_length,
  output logic        out_truncated,
  output logic        out_last_code
);
  import hcb_pkg::*;

  localparam int NSLOT = 2 * MAX_SYMBOLS;
  localparam int NB    = $clog2(NSLOT);
  localparam int WB    = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
  localparam int QB    = $clog2(MAX_SYMBOLS + 1);
  localparam int SB    = $clog2(MAX_SYMBOLS);
  localparam int NEW   = 2 * NB + 9;
  localparam int SEW   = NB + 19;

  typedef struct packed {
    logic [NB-1:0] node;
    logic [WB-1:0] weight;
  } qcell_t;

  // node table: {leaf, zero child, one child, symbol}
  logic [NEW-1:0] node_mem [NSLOT];
  logic [NEW-1:0] node_rd_q;
  logic           node_we;
  logic [NB-1:0]  node_wa, node_ra;
  logic [NEW-1:0] node_wd;

  // walk stack: {node, code, length}
  logic [SEW-1:0] stk_mem [MAX_SYMBOLS];
  logic [SEW-1:0] stk_rd_q;
  logic           stk_we;
  logic [SB-1:0]  stk_wa, stk_ra;
  logic [SEW-1:0] stk_wd;

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    node_rd_q <= node_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd_q <= stk_mem[stk_ra];
  end

  hcb_state_t     state_r, state_nxt;
  qcell_t         q_r [MAX_SYMBOLS];
  qcell_t         q_nxt [MAX_SYMBOLS];
  logic [QB-1:0]  qcnt_r, qcnt_nxt;
  logic [NB-1:0]  nc_r, nc_nxt;
  logic           drop_r, drop_nxt;
  logic [NB-1:0]  cur_node_r, cur_node_nxt;
  logic [14:0]    cur_code_r, cur_code_nxt;
  logic [3:0]     cur_len_r, cur_len_nxt;
  logic [SB:0]    sp_r, sp_nxt;

  logic           ov_r, ov_nxt;
  logic [7:0]     osym_r, osym_nxt;
  logic [14:0]    obits_r, obits_nxt;
  logic [3:0]     olen_r, olen_nxt;
  logic           otrunc_r, otrunc_nxt;
  logic           olast_r, olast_nxt;

  logic           accept;
  logic [WB-1:0]  w_in;
  qcell_t         ins_cell;
  qcell_t         ins_q [MAX_SYMBOLS];
  logic [MAX_SYMBOLS-1:0] ins_le;
  qcell_t         rem_q [MAX_SYMBOLS];
  qcell_t         mrg_q [MAX_SYMBOLS];
  logic [MAX_SYMBOLS-1:0] mrg_le;
  logic [WB-1:0]  sum_w;
  logic [QB-1:0]  rem_cnt;

  logic           rd_leaf;
  logic [NB-1:0]  rd_zero, rd_one;
  logic [7:0]     rd_sym;

  assign accept = start && (state_r == S_LOAD);
  assign busy   = (state_r != S_LOAD);

  assign rd_leaf = node_rd_q[NEW-1];
  assign rd_zero = node_rd_q[NEW-2 -: NB];
  assign rd_one  = node_rd_q[NB+7 -: NB];
  assign rd_sym  = node_rd_q[7:0];

  // input weight masked to WEIGHT_BITS, zero extended to the sum width
  always_comb begin
    w_in = '0;
    for (int b = 0; b < WB; b++) begin
      if (b < WEIGHT_BITS && b < 16) w_in[b] = in_weight[b[3:0]];
    end
  end

  // sorted insert of a new leaf: lands after every entry of equal or lower weight
  always_comb begin
    ins_cell.node   = nc_r;
    ins_cell.weight = w_in;
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      ins_le[i] = (QB'(i) < qcnt_r) && (q_r[i].weight <= w_in);
    end
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (ins_le[i]) ins_q[i] = q_r[i];
      else if (i == 0) ins_q[i] = ins_cell;
      else if (ins_le[i-1]) ins_q[i] = ins_cell;
      else ins_q[i] = q_r[i-1];
    end
  end

  // merge: drop the two lowest, insert their parent by the same rule
  always_comb begin
    sum_w   = q_r[0].weight + q_r[1].weight;
    rem_cnt = qcnt_r - QB'(2);
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (i + 2 < MAX_SYMBOLS) rem_q[i] = q_r[i+2];
      else rem_q[i] = q_r[MAX_SYMBOLS-1];
    end
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      mrg_le[i] = (QB'(i) < rem_cnt) && (rem_q[i].weight <= sum_w);
    end
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (mrg_le[i]) mrg_q[i] = rem_q[i];
      else if (i == 0 || mrg_le[i-1]) begin
        mrg_q[i].node   = nc_r;
        mrg_q[i].weight = sum_w;
      end else mrg_q[i] = rem_q[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      qcnt_r  <= '0;
      nc_r    <= '0;
      drop_r  <= 1'b0;
      sp_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      qcnt_r  <= qcnt_nxt;
      nc_r    <= nc_nxt;
      drop_r  <= drop_nxt;
      sp_r    <= sp_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    cur_node_r <= cur_node_nxt;
    cur_code_r <= cur_code_nxt;
    cur_len_r  <= cur_len_nxt;
    osym_r     <= osym_nxt;
    obits_r    <= obits_nxt;
    olen_r     <= olen_nxt;
    otrunc_r   <= otrunc_nxt;
    olast_r    <= olast_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    q_nxt        = q_r;
    qcnt_nxt     = qcnt_r;
    nc_nxt       = nc_r;
    drop_nxt     = drop_r;
    sp_nxt       = sp_r;
    cur_node_nxt = cur_node_r;
    cur_code_nxt = cur_code_r;
    cur_len_nxt  = cur_len_r;
    ov_nxt       = 1'b0;
    osym_nxt     = osym_r;
    obits_nxt    = obits_r;
    olen_nxt     = olen_r;
    otrunc_nxt   = otrunc_r;
    olast_nxt    = 1'b0;
    node_we      = 1'b0;
    node_wa      = nc_r;
    node_wd      = '0;
    node_ra      = cur_node_r;
    stk_we       = 1'b0;
    stk_wa       = sp_r[SB-1:0];
    stk_wd       = '0;
    stk_ra       = sp_r[SB-1:0] - SB'(1);

    case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (nc_r < NB'(MAX_SYMBOLS)) begin
            node_we  = 1'b1;
            node_wd  = {1'b1, {NB{1'b0}}, {NB{1'b0}}, in_symbol};
            q_nxt    = ins_q;
            qcnt_nxt = qcnt_r + QB'(1);
            nc_nxt   = nc_r + NB'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last_symbol) state_nxt = S_BUILD;
        end
      end
      S_BUILD: begin
        if (qcnt_r > QB'(1)) begin
          node_we  = 1'b1;
          node_wd  = {1'b0, q_r[0].node, q_r[1].node, 8'd0};
          q_nxt    = mrg_q;
          qcnt_nxt = qcnt_r - QB'(1);
          nc_nxt   = nc_r + NB'(1);
        end else begin
          cur_node_nxt = q_r[0].node;
          cur_code_nxt = '0;
          cur_len_nxt  = '0;
          sp_nxt       = '0;
          state_nxt    = S_WRD;
        end
      end
      S_WRD: begin
        state_nxt = S_WEV;
      end
      S_WEV: begin
        if (rd_leaf) begin
          ov_nxt     = 1'b1;
          osym_nxt   = rd_sym;
          obits_nxt  = cur_code_r;
          olen_nxt   = cur_len_r;
          otrunc_nxt = drop_r;
          if (sp_r == '0) begin
            olast_nxt = 1'b1;
            qcnt_nxt  = '0;
            nc_nxt    = '0;
            drop_nxt  = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            sp_nxt    = sp_r - (SB+1)'(1);
            state_nxt = S_POP;
          end
        end else begin
          // one child waits on the stack, zero child is walked next
          stk_we       = 1'b1;
          stk_wd       = {rd_one, cur_code_r[13:0], 1'b1, cur_len_r + 4'd1};
          sp_nxt       = sp_r + (SB+1)'(1);
          cur_node_nxt = rd_zero;
          cur_code_nxt = {cur_code_r[13:0], 1'b0};
          cur_len_nxt  = cur_len_r + 4'd1;
          state_nxt    = S_WRD;
        end
      end
      S_POP: begin
        cur_node_nxt = stk_rd_q[SEW-1 -: NB];
        cur_code_nxt = stk_rd_q[18:4];
        cur_len_nxt  = stk_rd_q[3:0];
        state_nxt    = S_WRD;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  assign out_valid       = ov_r;
  assign out_code_symbol = osym_r;
  assign out_code_bits   = obits_r;
  assign out_code_length = olen_r;
  assign out_truncated   = otrunc_r;
  assign out_last_code   = olast_r;

  a_out_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_WEV))
    else $error("code word without a node evaluation");

  a_qcnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= QB'(MAX_SYMBOLS))
    else $error("queue overfilled");

  a_build_slots: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BUILD && qcnt_r > QB'(1)) |-> (nc_r < NB'(NSLOT - 1)))
    else $error("node table overrun");

  a_stack_cap: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r < (SB+1)'(MAX_SYMBOLS))
    else $error("walk stack overrun");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_code) |-> (state_r == S_LOAD && qcnt_r == '0))
    else $error("set not cleared after last code");

endmodule
